[rtl/lsm_pkg.sv]
`default_nettype none
package lsm_pkg;

    localparam int NEEDLE_MAX = 128;
    // wide enough to hold the needle length up to NEEDLE_MAX itself
    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;

    localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TEXT = 2'd1,
        OP_EOF  = 2'd2
    } opcode_t;

    typedef enum logic {
        REG_CASE_FOLD     = 1'b0,
        REG_NEEDLE_LENGTH = 1'b1
    } cfg_reg_t;

    // per-cell controls decoded at the top level
    typedef struct packed {
        logic load;
        logic active;
        logic tail;
    } lsm_cell_ctl_t;

    // broadcast to every cell
    typedef struct packed {
        logic       shift;
        logic       clear;
        logic       fold;
        logic [7:0] text;
        logic [7:0] load_byte;
    } lsm_bus_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
        if (fold && b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
            return b - CHAR_LOW_A + CHAR_UP_A;
        end
        return b;
    endfunction

endpackage
`default_nettype wire

[rtl/lsm_cell.sv]
`default_nettype none
module lsm_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lsm_pkg::lsm_cell_ctl_t ctl,
    input  wire lsm_pkg::lsm_bus_t      bus,
    input  wire logic                  prev_match,
    output logic                       match_out,
    output logic                       hit_out
);

    logic [7:0] needle_reg;
    logic       match_reg;
    logic       match_next;
    logic       cmp_bit;

    // text byte on the bus is already folded
    assign cmp_bit = prev_match &&
                     (lsm_pkg::fold_byte(needle_reg, bus.fold) == bus.text);

    always_comb begin
        match_next = match_reg;
        if (bus.clear) begin
            match_next = 1'b0;
        end else if (bus.shift && ctl.active) begin
            match_next = cmp_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            needle_reg <= bus.load_byte;
        end
    end

    assign match_out = match_reg;
    // last cell of the needle reports a full match ending at this byte
    assign hit_out   = ctl.tail && cmp_bit;

endmodule
`default_nettype wire

[rtl/line_substring_matcher_unit.sv]
// line substring matcher
// input channel (s_*): one request per cycle. opcode load writes a needle
// byte at s_needle_index, opcode text feeds one file byte, opcode end of
// file closes the file. lines end at LF, at a zero text byte and at end of
// file; a CR just before the line end is not part of the line.
// result channel (m_*): one request per ended line with its 1-based number
// (saturating), the hit flag, the file end flag and, on file end, whether
// any line of the file matched.
// config channel (cfg_*): index 0 case fold, index 1 needle length; always
// ready; the user must write it only while the block is idle, which the block itself does not enforce.
// a result shows on m_valid in the cycle after the ending request.
// throughput: one request per cycle; a row of one cell per needle byte
// compares every needle position against each text byte in that cycle.
// when the receiver stalls, the result holds in the output register and
// s_ready drops until it is taken; requests that end no line still need
// s_ready.
// reset clears line state, counters and both config registers; needle bytes
// are undefined until loaded. no clearing pass is needed.
`default_nettype none
module line_substring_matcher_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [6:0]  s_needle_index,
    input  wire logic [7:0]  s_byte_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_line_number,
    output logic             m_line_hit,
    output logic             m_file_end,
    output logic             m_any_match,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int N = lsm_pkg::NEEDLE_MAX;

    logic                      case_fold_reg;
    logic [7:0]                needle_length_reg;
    logic [lsm_pkg::LEN_W-1:0] len_used;

    logic        line_found_reg, line_found_next;
    logic        cr_pending_reg, cr_pending_next;
    logic        last_cr_reg, last_cr_next;
    logic [31:0] line_cnt_reg, line_cnt_next;
    logic        matched_any_reg, matched_any_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_line_reg;
    logic        out_hit_reg, out_end_reg, out_any_reg;

    logic accept, load_en, shift_en, end_last, end_mid, end_any;
    logic len_zero, byte_hit, line_hit_now;
    logic [31:0] cnt_inc;

    lsm_pkg::lsm_bus_t      bus;
    lsm_pkg::lsm_cell_ctl_t ctl [N];
    logic [N-1:0]           match_vec;
    logic [N-1:0]           hit_vec;

    assign s_ready   = !out_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    always_comb begin
        load_en  = 1'b0;
        shift_en = 1'b0;
        end_last = 1'b0;
        end_mid  = 1'b0;
        case (s_opcode)
            lsm_pkg::OP_LOAD: begin
                load_en = accept;
            end
            lsm_pkg::OP_TEXT: begin
                if (s_byte_value == lsm_pkg::CHAR_NUL) begin
                    end_last = accept;
                end else if (s_byte_value == lsm_pkg::CHAR_LF) begin
                    end_mid = accept;
                end else begin
                    shift_en = accept;
                end
            end
            lsm_pkg::OP_EOF: begin
                end_last = accept;
            end
            default: begin
            end
        endcase
    end
    assign end_any = end_last || end_mid;

    assign len_used = (32'(needle_length_reg) > N) ? lsm_pkg::LEN_W'(N)
                                                   : lsm_pkg::LEN_W'(needle_length_reg);
    assign len_zero = (len_used == '0);

    assign bus.shift     = shift_en;
    assign bus.clear     = end_any;
    assign bus.fold      = case_fold_reg;
    assign bus.text      = lsm_pkg::fold_byte(s_byte_value, case_fold_reg);
    assign bus.load_byte = s_byte_value;

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic prev;
        if (k == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_link
            assign prev = match_vec[k-1];
        end
        assign ctl[k].load   = load_en && (32'(s_needle_index) == k);
        assign ctl[k].active = (32'(len_used) > k);
        assign ctl[k].tail   = (32'(len_used) == k + 1);

        lsm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl[k]),
            .bus        (bus),
            .prev_match (prev),
            .match_out  (match_vec[k]),
            .hit_out    (hit_vec[k])
        );
    end

    assign byte_hit     = len_zero || (|hit_vec);
    assign line_hit_now = line_found_reg || len_zero;
    assign cnt_inc      = (line_cnt_reg == lsm_pkg::LINE_MAX) ? line_cnt_reg
                                                              : line_cnt_reg + 32'd1;

    always_comb begin
        line_found_next  = line_found_reg;
        cr_pending_next  = cr_pending_reg;
        last_cr_next     = last_cr_reg;
        line_cnt_next    = line_cnt_reg;
        matched_any_next = matched_any_reg;
        if (end_any) begin
            line_found_next = 1'b0;
            cr_pending_next = 1'b0;
            last_cr_next    = 1'b0;
            if (end_last) begin
                line_cnt_next    = '0;
                matched_any_next = 1'b0;
            end else begin
                line_cnt_next    = cnt_inc;
                matched_any_next = matched_any_reg || line_hit_now;
            end
        end else if (shift_en) begin
            // a match ending on a CR counts once an ordinary byte follows
            if (last_cr_reg && cr_pending_reg) begin
                line_found_next = 1'b1;
            end
            if (s_byte_value == lsm_pkg::CHAR_CR) begin
                cr_pending_next = byte_hit;
                last_cr_next    = 1'b1;
            end else begin
                if (byte_hit) begin
                    line_found_next = 1'b1;
                end
                cr_pending_next = 1'b0;
                last_cr_next    = 1'b0;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (end_any) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_found_reg    <= 1'b0;
            cr_pending_reg    <= 1'b0;
            last_cr_reg       <= 1'b0;
            line_cnt_reg      <= '0;
            matched_any_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            case_fold_reg     <= 1'b0;
            needle_length_reg <= '0;
        end else begin
            line_found_reg  <= line_found_next;
            cr_pending_reg  <= cr_pending_next;
            last_cr_reg     <= last_cr_next;
            line_cnt_reg    <= line_cnt_next;
            matched_any_reg <= matched_any_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lsm_pkg::REG_CASE_FOLD:     case_fold_reg     <= cfg_data[0];
                    lsm_pkg::REG_NEEDLE_LENGTH: needle_length_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (end_any) begin
            out_line_reg <= cnt_inc;
            out_hit_reg  <= line_hit_now;
            out_end_reg  <= end_last;
            out_any_reg  <= end_last && (matched_any_reg || line_hit_now);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_line_number = out_line_reg;
    assign m_line_hit    = out_hit_reg;
    assign m_file_end    = out_end_reg;
    assign m_any_match   = out_any_reg;

endmodule
`default_nettype wire

[rtl/lsm_checker.sv]
`default_nettype none
module lsm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_opcode,
    input wire logic [7:0]  s_byte_value,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_line_number,
    input wire logic        m_line_hit,
    input wire logic        m_file_end,
    input wire logic        m_any_match
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_line_number)
                                   && $stable(m_line_hit) && $stable(m_file_end)))
        else $error("stalled result changed");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_number != 32'd0))
        else $error("line number zero");

    a_any_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_file_end) |-> !m_any_match)
        else $error("any match outside file end");

    a_hit_implies_any: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_file_end && m_line_hit) |-> m_any_match)
        else $error("final line hit without any match");

    // an LF request shows its result in the next cycle
    a_lf_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == lsm_pkg::OP_TEXT
         && s_byte_value == lsm_pkg::CHAR_LF) |=> (m_valid && !m_file_end))
        else $error("line end without result");

endmodule

bind line_substring_matcher_unit lsm_checker u_lsm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_opcode      (s_opcode),
    .s_byte_value  (s_byte_value),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_line_number (m_line_number),
    .m_line_hit    (m_line_hit),
    .m_file_end    (m_file_end),
    .m_any_match   (m_any_match)
);
`default_nettype wire

[verif/lsm_checker.sv]
`timescale 1ns / 1ps
module lsm_scoreboard (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [6:0]  s_needle_index,
    input  wire logic [7:0]  s_byte_value,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_line_number,
    input  wire logic        m_line_hit,
    input  wire logic        m_file_end,
    input  wire logic        m_any_match,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output int               errors,
    output int               pending
);

    typedef struct packed {
        logic [31:0] number;
        logic        hit;
        logic        eof;
        logic        any_hit;
    } line_result_t;

    line_result_t expected_lines[$];

    logic [7:0]  needle_mem [lsm_pkg::NEEDLE_MAX];
    bit          cell_hit [lsm_pkg::NEEDLE_MAX];
    bit          found_in_line;
    bit          cr_hit_held;
    bit          prev_cr;
    bit          any_line_hit;
    bit          fold_on;
    logic [7:0]  needle_len;
    logic [31:0] line_count;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        if (fold_on && b >= lsm_pkg::CHAR_LOW_A && b <= lsm_pkg::CHAR_LOW_Z) begin
            return b - lsm_pkg::CHAR_LOW_A + lsm_pkg::CHAR_UP_A;
        end
        return b;
    endfunction

    function automatic int used_len();
        return (needle_len > lsm_pkg::NEEDLE_MAX) ? lsm_pkg::NEEDLE_MAX : int'(needle_len);
    endfunction

    // advance every cell within the needle length by one text byte, true when the needle ends here
    function automatic bit shift_cells(input logic [7:0] b);
        int  len;
        bit  prev;
        logic [7:0] t;
        len = used_len();
        t = upcase(b);
        if (len == 0) begin
            return 1'b1;
        end
        for (int k = len - 1; k >= 0; k--) begin
            prev = (k == 0) ? 1'b1 : cell_hit[k - 1];
            cell_hit[k] = prev && (upcase(needle_mem[k]) == t);
        end
        return cell_hit[len - 1];
    endfunction

    task automatic clear_cells();
        for (int k = 0; k < lsm_pkg::NEEDLE_MAX; k++) begin
            cell_hit[k] = 1'b0;
        end
        found_in_line = 1'b0;
        cr_hit_held = 1'b0;
        prev_cr = 1'b0;
    endtask

    task automatic close_line(input bit eof);
        line_result_t r;
        bit hit;
        hit = found_in_line || (used_len() == 0);
        if (line_count != lsm_pkg::LINE_MAX) begin
            line_count++;
        end
        if (hit) begin
            any_line_hit = 1'b1;
        end
        r.number = line_count;
        r.hit = hit;
        r.eof = eof;
        r.any_hit = eof && any_line_hit;
        expected_lines.push_back(r);
        clear_cells();
        if (eof) begin
            line_count = '0;
            any_line_hit = 1'b0;
        end
    endtask

    task automatic take_request(input logic [1:0] op, input logic [6:0] idx,
                                input logic [7:0] b);
        bit hit;
        case (lsm_pkg::opcode_t'(op))
            lsm_pkg::OP_LOAD: begin
                needle_mem[idx] = b;
            end
            lsm_pkg::OP_EOF: begin
                close_line(1'b1);
            end
            lsm_pkg::OP_TEXT: begin
                if (b == lsm_pkg::CHAR_NUL) begin
                    close_line(1'b1);
                end else if (b == lsm_pkg::CHAR_LF) begin
                    close_line(1'b0);
                end else begin
                    // a match held on a CR counts once an ordinary byte follows
                    if (prev_cr && cr_hit_held) begin
                        found_in_line = 1'b1;
                    end
                    hit = shift_cells(b);
                    if (b == lsm_pkg::CHAR_CR) begin
                        cr_hit_held = hit;
                        prev_cr = 1'b1;
                    end else begin
                        if (hit) begin
                            found_in_line = 1'b1;
                        end
                        cr_hit_held = 1'b0;
                        prev_cr = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_result();
        line_result_t want;
        if (expected_lines.size() == 0) begin
            report("result with no line pending", m_line_number, '0);
        end else begin
            want = expected_lines.pop_front();
            if (m_line_number !== want.number) begin
                report("line_number", m_line_number, want.number);
            end
            if (m_line_hit !== want.hit) begin
                report("line_hit", 32'(m_line_hit), 32'(want.hit));
            end
            if (m_file_end !== want.eof) begin
                report("file_end", 32'(m_file_end), 32'(want.eof));
            end
            if (m_any_match !== want.any_hit) begin
                report("any_match", 32'(m_any_match), 32'(want.any_hit));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_lines.delete();
            clear_cells();
            line_count = '0;
            any_line_hit = 1'b0;
            fold_on = 1'b0;
            needle_len = '0;
            errors = 0;
        end else begin
            // results are registered and trail their request
            if (m_valid && m_ready) begin
                check_result();
            end
            if (cfg_valid && cfg_ready) begin
                case (lsm_pkg::cfg_reg_t'(cfg_index))
                    lsm_pkg::REG_CASE_FOLD:     fold_on = cfg_data[0];
                    lsm_pkg::REG_NEEDLE_LENGTH: needle_len = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                take_request(s_opcode, s_needle_index, s_byte_value);
            end
        end
        pending = expected_lines.size();
    end

endmodule

[verif/tb_line_substring_matcher_unit.sv]
`timescale 1ns / 1ps
module tb_line_substring_matcher_unit;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] CHAR_UP_Z = lsm_pkg::CHAR_UP_A + 8'd25;
    localparam logic [7:0] CASE_GAP  = lsm_pkg::CHAR_LOW_A - lsm_pkg::CHAR_UP_A;
    localparam int ITEMS_TOTAL = 1900;
    localparam int STALL_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = lsm_pkg::OP_TEXT;
    logic [6:0]  s_needle_index = '0;
    logic [7:0]  s_byte_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_line_number;
    logic        m_line_hit;
    logic        m_file_end;
    logic        m_any_match;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    int errors;
    int pending;

    logic [7:0] pattern [lsm_pkg::NEEDLE_MAX];
    bit         loaded [lsm_pkg::NEEDLE_MAX];
    bit         cur_fold;
    int         cur_len;
    bit         steady;
    int         items_sent;
    int         hold_cnt;
    int         idle_cycles;

    always #1 aclk = ~aclk;

    line_substring_matcher_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_needle_index (s_needle_index),
        .s_byte_value   (s_byte_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_number  (m_line_number),
        .m_line_hit     (m_line_hit),
        .m_file_end     (m_file_end),
        .m_any_match    (m_any_match),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    lsm_scoreboard chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_needle_index (s_needle_index),
        .s_byte_value   (s_byte_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_number  (m_line_number),
        .m_line_hit     (m_line_hit),
        .m_file_end     (m_file_end),
        .m_any_match    (m_any_match),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending)
    );

    // receiver backpressure
    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:59]: begin
                    m_ready <= 1'b1;
                    hold_cnt = $urandom_range(0, 8);
                end
                [60:91]: begin
                    m_ready <= 1'b0;
                    hold_cnt = $urandom_range(0, 3);
                end
                default: begin
                    m_ready <= 1'b0;
                    hold_cnt = $urandom_range(10, 50);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        if (steady) begin
            return 0;
        end
        case ($urandom_range(0, 99)) inside
            [0:54]:  return 0;
            [55:89]: return $urandom_range(1, 3);
            [90:97]: return $urandom_range(4, 12);
            default: return $urandom_range(20, 60);
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] b);
        if (b >= lsm_pkg::CHAR_LOW_A && b <= lsm_pkg::CHAR_LOW_Z) begin
            return b - CASE_GAP;
        end
        if (b >= lsm_pkg::CHAR_UP_A && b <= CHAR_UP_Z) begin
            return b + CASE_GAP;
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] b;
        b = lsm_pkg::CHAR_LOW_A + 8'($urandom_range(0, 2));
        return $urandom_range(0, 1) ? flip_case(b) : b;
    endfunction

    function automatic logic [7:0] pick_needle_byte();
        case ($urandom_range(0, 99)) inside
            [0:69]:  return pick_letter();
            [70:79]: return lsm_pkg::CHAR_CR;
            [80:83]: return lsm_pkg::CHAR_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [6:0] idx,
                             input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_needle_index <= idx;
        s_byte_value <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != OP_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input logic [7:0] b);
        send_item(lsm_pkg::OP_TEXT, 7'($urandom_range(0, 127)), b);
    endtask

    task automatic load_byte(input int idx, input logic [7:0] b);
        send_item(lsm_pkg::OP_LOAD, 7'(idx), b);
        pattern[idx] = b;
        loaded[idx] = 1'b1;
    endtask

    // hold the sender until every pending line has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input lsm_pkg::cfg_reg_t r, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic new_setting(input bit fold, input int len);
        int used;
        used = (len > lsm_pkg::NEEDLE_MAX) ? lsm_pkg::NEEDLE_MAX : len;
        // long needles keep their bytes, short ones get fresh content
        for (int k = 0; k < used; k++) begin
            if (!loaded[k] || used <= 16) begin
                load_byte(k, pick_needle_byte());
            end
        end
        drain();
        write_reg(lsm_pkg::REG_CASE_FOLD, 8'(fold));
        write_reg(lsm_pkg::REG_NEEDLE_LENGTH, 8'(len));
        cur_fold = fold;
        cur_len = used;
    endtask

    task automatic send_needle_copy();
        int bad;
        logic [7:0] b;
        bad = -1;
        if (cur_len > 0 && $urandom_range(0, 99) < 15) begin
            bad = $urandom_range(0, cur_len - 1);
        end
        for (int k = 0; k < cur_len; k++) begin
            b = pattern[k];
            if (cur_fold && $urandom_range(0, 1)) begin
                b = flip_case(b);
            end
            if (k == bad) begin
                b = pick_letter();
            end
            send_text(b);
        end
    endtask

    task automatic send_line();
        int pieces;
        int idx;
        pieces = $urandom_range(0, 6);
        for (int p = 0; p < pieces; p++) begin
            case ($urandom_range(0, 99)) inside
                [0:39]:  send_needle_copy();
                [40:74]: send_text(pick_letter());
                [75:81]: send_text(lsm_pkg::CHAR_CR);
                [82:85]: send_item(OP_UNUSED, 7'($urandom_range(0, 127)),
                                   8'($urandom_range(0, 255)));
                [86:89]: begin
                    // needle change in the middle of a line
                    idx = $urandom_range(0, lsm_pkg::NEEDLE_MAX - 1);
                    load_byte(idx, pick_needle_byte());
                end
                default: send_text(8'($urandom_range(1, 255)));
            endcase
        end
        case ($urandom_range(0, 99)) inside
            [0:69]: send_text(lsm_pkg::CHAR_LF);
            [70:79]: begin
                send_text(lsm_pkg::CHAR_CR);
                send_text(lsm_pkg::CHAR_LF);
            end
            [80:87]: send_item(lsm_pkg::OP_EOF, 7'($urandom_range(0, 127)),
                               8'($urandom_range(0, 255)));
            [88:93]: send_text(lsm_pkg::CHAR_NUL);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int phase_no);
        int len;
        int lines;
        bit fold;
        fold = $urandom_range(0, 1);
        case ($urandom_range(0, 99)) inside
            [0:5]:   len = 0;
            [6:69]:  len = $urandom_range(1, 4);
            [70:95]: len = $urandom_range(5, 16);
            default: len = $urandom_range(0, 1) ? lsm_pkg::NEEDLE_MAX
                                                : $urandom_range(129, 255);
        endcase
        if (phase_no == 0) begin
            fold = 1'b1;
            len = 255;
        end else if (phase_no == 1) begin
            fold = 1'b0;
            len = 0;
        end
        new_setting(fold, len);
        steady = ($urandom_range(0, 4) == 0);
        lines = (cur_len > 16) ? $urandom_range(2, 3) : $urandom_range(4, 14);
        for (int n = 0; n < lines; n++) begin
            send_line();
        end
    endtask

    initial begin
        int phase_no;
        steady = 1'b0;
        hold_cnt = 0;
        items_sent = 0;
        idle_cycles = 0;
        cur_fold = 1'b0;
        cur_len = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty needle hits every line, then a trailing empty final line
        send_text("x");
        send_text(lsm_pkg::CHAR_LF);
        send_item(lsm_pkg::OP_EOF, 7'd0, 8'd0);
        // needle "a" CR, plus the top store entry
        load_byte(0, "a");
        load_byte(1, lsm_pkg::CHAR_CR);
        load_byte(lsm_pkg::NEEDLE_MAX - 1, 8'hFF);
        drain();
        write_reg(lsm_pkg::REG_NEEDLE_LENGTH, 8'd2);
        cur_len = 2;
        // match ending on the stripped CR does not count
        send_text("a");
        send_text(lsm_pkg::CHAR_CR);
        send_text(lsm_pkg::CHAR_LF);
        // same match followed by an ordinary byte does
        send_text("a");
        send_text(lsm_pkg::CHAR_CR);
        send_text("z");
        send_text(lsm_pkg::CHAR_LF);
        send_item(lsm_pkg::OP_EOF, 7'd127, 8'hFF);
        // zero text byte ends the file
        send_text("q");
        send_text(lsm_pkg::CHAR_NUL);
        send_item(OP_UNUSED, 7'd127, 8'hFF);
        send_text(8'hFF);
        send_text(lsm_pkg::CHAR_LF);

        phase_no = 0;
        while (items_sent < ITEMS_TOTAL) begin
            run_phase(phase_no);
            phase_no++;
        end

        steady = 1'b0;
        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[line_substring_matcher_unit.f]
rtl/lsm_pkg.sv
rtl/lsm_cell.sv
rtl/line_substring_matcher_unit.sv
rtl/lsm_checker.sv
verif/lsm_checker.sv
verif/tb_line_substring_matcher_unit.sv
